@@ design/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, widths and register codes for the triangle stress pipeline.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int COEF_W  = 40;
    localparam int AREA_W  = 67;
    localparam int STRN_W  = 67;
    localparam int SHRN_W  = 68;
    localparam int PROD_W  = 108;
    localparam int QUOT_W  = 63;
    localparam int CFG_IDX_W = 2;

    localparam logic [COEF_W-1:0] COEF_DIAG_RST  = 40'd281318681318;
    localparam logic [COEF_W-1:0] COEF_OFF_RST   = 40'd84395604396;
    localparam logic [COEF_W-1:0] COEF_SHEAR_RST = 40'd98461538462;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_DIAG  = 2'd0,
        CFG_COEF_OFF   = 2'd1,
        CFG_COEF_SHEAR = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic signed [31:0] x_one;
        logic signed [31:0] y_one;
        logic signed [31:0] x_two;
        logic signed [31:0] y_two;
        logic signed [31:0] x_three;
        logic signed [31:0] y_three;
        logic signed [31:0] disp_x_one;
        logic signed [31:0] disp_y_one;
        logic signed [31:0] disp_x_two;
        logic signed [31:0] disp_y_two;
        logic signed [31:0] disp_x_three;
        logic signed [31:0] disp_y_three;
    } in_t;

    typedef struct packed {
        logic signed [63:0] stress_xx;
        logic signed [63:0] stress_yy;
        logic signed [63:0] shear_by_area;
        logic               degenerate;
    } out_t;

    typedef struct packed {
        logic signed [STRN_W-1:0] exn;
        logic signed [STRN_W-1:0] eyn;
        logic signed [SHRN_W-1:0] gn;
        logic signed [AREA_W-1:0] two_a;
    } geom_t;

    typedef struct packed {
        logic        neg_x;
        logic        neg_y;
        logic        ovf_x;
        logic        ovf_y;
        logic        degen;
        logic [63:0] shear;
    } side_t;

    typedef struct packed {
        logic [PROD_W-1:0] num_x;
        logic [PROD_W-1:0] num_y;
        logic [AREA_W-1:0] den;
        side_t             side;
    } dv_t;

    typedef struct packed {
        logic [AREA_W-1:0] rem_x;
        logic [AREA_W-1:0] rem_y;
        logic [QUOT_W-1:0] low_x;
        logic [QUOT_W-1:0] low_y;
        logic [QUOT_W-1:0] q_x;
        logic [QUOT_W-1:0] q_y;
        logic [AREA_W-1:0] den;
        side_t             side;
    } ds_t;

endpackage

@@ design/cst_geom.sv @@
// ----------------------------------------------------------------------------
// cst_geom
// Edge differences, strain numerator products and sums, twice the area.
// ----------------------------------------------------------------------------
module cst_geom (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  cst_pkg::in_t   in_d,
    output logic           out_vld,
    output cst_pkg::geom_t out_d
);

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [32:0]   b_reg [3];
    logic signed [32:0]   c_reg [3];
    logic signed [31:0]   ux_reg [3];
    logic signed [31:0]   uy_reg [3];
    logic signed [64:0]   pbx_reg [3];
    logic signed [64:0]   pcy_reg [3];
    logic signed [64:0]   pcx_reg [3];
    logic signed [64:0]   pby_reg [3];
    logic signed [65:0]   a1_reg, a2_reg;
    cst_pkg::geom_t       g_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg[0] <= 33'(in_d.y_two) - 33'(in_d.y_three);
            b_reg[1] <= 33'(in_d.y_three) - 33'(in_d.y_one);
            b_reg[2] <= 33'(in_d.y_one) - 33'(in_d.y_two);
            c_reg[0] <= 33'(in_d.x_three) - 33'(in_d.x_two);
            c_reg[1] <= 33'(in_d.x_one) - 33'(in_d.x_three);
            c_reg[2] <= 33'(in_d.x_two) - 33'(in_d.x_one);
            ux_reg[0] <= in_d.disp_x_one;
            ux_reg[1] <= in_d.disp_x_two;
            ux_reg[2] <= in_d.disp_x_three;
            uy_reg[0] <= in_d.disp_y_one;
            uy_reg[1] <= in_d.disp_y_two;
            uy_reg[2] <= in_d.disp_y_three;
            for (int i = 0; i < 3; i++)
            begin
                pbx_reg[i] <= 65'(b_reg[i]) * 65'(ux_reg[i]);
                pcy_reg[i] <= 65'(c_reg[i]) * 65'(uy_reg[i]);
                pcx_reg[i] <= 65'(c_reg[i]) * 65'(ux_reg[i]);
                pby_reg[i] <= 65'(b_reg[i]) * 65'(uy_reg[i]);
            end
            a1_reg <= 66'(c_reg[2]) * 66'(b_reg[1]);
            a2_reg <= 66'(c_reg[1]) * 66'(b_reg[2]);
            g_reg.exn <= 67'(pbx_reg[0]) + 67'(pbx_reg[1]) + 67'(pbx_reg[2]);
            g_reg.eyn <= 67'(pcy_reg[0]) + 67'(pcy_reg[1]) + 67'(pcy_reg[2]);
            g_reg.gn  <= 68'(pcx_reg[0]) + 68'(pby_reg[0]) + 68'(pcx_reg[1])
                       + 68'(pby_reg[1]) + 68'(pcx_reg[2]) + 68'(pby_reg[2]);
            g_reg.two_a <= 67'(a1_reg) - 67'(a2_reg);
        end
    end

    assign out_vld = v3_reg;
    assign out_d   = g_reg;

endmodule

@@ design/cst_mac.sv @@
// ----------------------------------------------------------------------------
// cst_mac
// Two-stage signed by unsigned coefficient multiplier built from narrow
// partial products.
// ----------------------------------------------------------------------------
module cst_mac #(
    parameter int AW = 67
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [AW-1:0]                a,
    input  logic [cst_pkg::COEF_W-1:0]          coef,
    output logic signed [cst_pkg::PROD_W-1:0]   p
);

    localparam int PW = cst_pkg::PROD_W;

    logic signed [68:0] ae;
    logic [42:0]        u00_reg, u01_reg, u10_reg, u11_reg;
    logic signed [43:0] s20_reg, s21_reg;
    logic [PW-1:0]      p_reg;

    assign ae = 69'(a);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u00_reg <= 43'(ae[22:0]) * 43'(coef[19:0]);
            u01_reg <= 43'(ae[22:0]) * 43'(coef[39:20]);
            u10_reg <= 43'(ae[45:23]) * 43'(coef[19:0]);
            u11_reg <= 43'(ae[45:23]) * 43'(coef[39:20]);
            s20_reg <= 44'($signed(ae[68:46])) * 44'($signed({1'b0, coef[19:0]}));
            s21_reg <= 44'($signed(ae[68:46])) * 44'($signed({1'b0, coef[39:20]}));
            p_reg   <= PW'(u00_reg) + (PW'(u01_reg) << 20) + (PW'(u10_reg) << 23)
                     + (PW'(u11_reg) << 43) + (PW'(s20_reg) << 46)
                     + (PW'(s21_reg) << 66);
        end
    end

    assign p = $signed(p_reg);

endmodule

@@ design/cst_coef.sv @@
// ----------------------------------------------------------------------------
// cst_coef
// Material matrix products, magnitudes for the divider, overflow detection
// and the scaled shear result.
// ----------------------------------------------------------------------------
module cst_coef (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [cst_pkg::COEF_W-1:0]  coef_diag,
    input  logic [cst_pkg::COEF_W-1:0]  coef_off,
    input  logic [cst_pkg::COEF_W-1:0]  coef_shear,
    input  logic                        in_vld,
    input  cst_pkg::geom_t              in_d,
    output logic                        out_vld,
    output cst_pkg::dv_t                out_d
);

    localparam int PW = cst_pkg::PROD_W;
    localparam int DW = cst_pkg::AREA_W;

    logic                 v4_reg, v5_reg, v6_reg, v7_reg;
    logic signed [PW-1:0] pdx, poy, pox, pdy, psh;
    logic signed [DW-1:0] a4_reg, a5_reg, a6_reg;
    logic                 z4_reg, z5_reg, z6_reg;
    logic signed [PW-1:0] sxn_reg, syn_reg, shp_reg;
    cst_pkg::dv_t         dv_reg;
    logic [PW-1:0]        nx, ny, nsh;
    logic [DW-1:0]        dm;
    logic [PW-34:0]       shr;

    cst_mac #(.AW(cst_pkg::STRN_W)) u_mdx (.clk, .en, .a(in_d.exn), .coef(coef_diag),
                                           .p(pdx));
    cst_mac #(.AW(cst_pkg::STRN_W)) u_moy (.clk, .en, .a(in_d.eyn), .coef(coef_off),
                                           .p(poy));
    cst_mac #(.AW(cst_pkg::STRN_W)) u_mox (.clk, .en, .a(in_d.exn), .coef(coef_off),
                                           .p(pox));
    cst_mac #(.AW(cst_pkg::STRN_W)) u_mdy (.clk, .en, .a(in_d.eyn), .coef(coef_diag),
                                           .p(pdy));
    cst_mac #(.AW(cst_pkg::SHRN_W)) u_msh (.clk, .en, .a(in_d.gn), .coef(coef_shear),
                                           .p(psh));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= in_vld;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_comb
    begin
        nx  = sxn_reg[PW-1] ? PW'(-sxn_reg) : PW'(sxn_reg);
        ny  = syn_reg[PW-1] ? PW'(-syn_reg) : PW'(syn_reg);
        nsh = shp_reg[PW-1] ? PW'(-shp_reg) : PW'(shp_reg);
        dm  = a6_reg[DW-1] ? DW'(-a6_reg) : DW'(a6_reg);
        shr = nsh[PW-1:33];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a4_reg  <= in_d.two_a;
            z4_reg  <= (in_d.two_a == '0);
            a5_reg  <= a4_reg;
            z5_reg  <= z4_reg;
            a6_reg  <= a5_reg;
            z6_reg  <= z5_reg;
            sxn_reg <= pdx + poy;
            syn_reg <= pox + pdy;
            shp_reg <= psh;
            dv_reg.num_x      <= nx;
            dv_reg.num_y      <= ny;
            dv_reg.den        <= dm;
            dv_reg.side.neg_x <= sxn_reg[PW-1] ^ a6_reg[DW-1];
            dv_reg.side.neg_y <= syn_reg[PW-1] ^ a6_reg[DW-1];
            dv_reg.side.ovf_x <= DW'(nx[PW-1:63]) >= dm;
            dv_reg.side.ovf_y <= DW'(ny[PW-1:63]) >= dm;
            dv_reg.side.degen <= z6_reg;
            if (|shr[PW-34:63])
                dv_reg.side.shear <= shp_reg[PW-1] ? 64'h8000_0000_0000_0000
                                                   : 64'h7FFF_FFFF_FFFF_FFFF;
            else
                dv_reg.side.shear <= shp_reg[PW-1] ? 64'(-{1'b0, shr[62:0]})
                                                   : {1'b0, shr[62:0]};
        end
    end

    assign out_vld = v7_reg;
    assign out_d   = dv_reg;

endmodule

@@ design/cst_div.sv @@
// ----------------------------------------------------------------------------
// cst_div
// Pipelined restoring divider, one quotient bit per stage for both normal
// stresses against the shared area magnitude.
// ----------------------------------------------------------------------------
module cst_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_vld,
    input  cst_pkg::dv_t  in_d,
    output logic          out_vld,
    output cst_pkg::ds_t  out_d
);

    localparam int QW = cst_pkg::QUOT_W;
    localparam int DW = cst_pkg::AREA_W;
    localparam int PW = cst_pkg::PROD_W;

    cst_pkg::ds_t st [QW+1];
    logic         v  [QW+1];

    always_comb
    begin
        st[0].rem_x = DW'(in_d.num_x[PW-1:QW]);
        st[0].rem_y = DW'(in_d.num_y[PW-1:QW]);
        st[0].low_x = in_d.num_x[QW-1:0];
        st[0].low_y = in_d.num_y[QW-1:0];
        st[0].q_x   = '0;
        st[0].q_y   = '0;
        st[0].den   = in_d.den;
        st[0].side  = in_d.side;
        v[0]        = in_vld;
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW:0]  tx, ty, dz;
        cst_pkg::ds_t nxt;
        cst_pkg::ds_t st_reg;
        logic         v_reg;

        always_comb
        begin
            dz  = {1'b0, st[k].den};
            tx  = {st[k].rem_x, st[k].low_x[QW-1-k]};
            ty  = {st[k].rem_y, st[k].low_y[QW-1-k]};
            nxt = st[k];
            if (tx >= dz)
            begin
                nxt.rem_x         = DW'(tx - dz);
                nxt.q_x[QW-1-k]   = 1'b1;
            end
            else
            begin
                nxt.rem_x = DW'(tx);
            end
            if (ty >= dz)
            begin
                nxt.rem_y         = DW'(ty - dz);
                nxt.q_y[QW-1-k]   = 1'b1;
            end
            else
            begin
                nxt.rem_y = DW'(ty);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (en)
                v_reg <= v[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                st_reg <= nxt;
        end

        assign st[k+1] = st_reg;
        assign v[k+1]  = v_reg;
    end

    assign out_vld = v[QW];
    assign out_d   = st[QW];

endmodule

@@ design/cst_element_stress_top.sv @@
// ----------------------------------------------------------------------------
// cst_element_stress_top
// Plane-stress stress of one constant-strain triangle per item.
// ----------------------------------------------------------------------------
// An item carries three vertex coordinates and six displacements on the
// input channel (in_valid, in_ready, in_data).  One result item per input
// item leaves on the output channel (out_valid, out_ready, out_data).
// The three material coefficients are written through the cfg channel,
// which is always ready; the user must write them only while the block is
// idle, as the block itself does not enforce this.  An item passes 71
// register stages: three geometry stages, four coefficient stages, a
// 63-stage divider that produces one quotient bit per stage, and the output
// register.  One item is accepted every cycle unless the receiver stalls.
// Reset clears all valid bits and loads the default coefficients.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module cst_element_stress_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  cst_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output cst_pkg::out_t                  out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cst_pkg::COEF_W-1:0]     cfg_data
);

    logic [cst_pkg::COEF_W-1:0] coef_diag_reg, coef_off_reg, coef_shear_reg;
    logic                       stage_en;
    logic                       g_vld, c_vld, d_vld;
    cst_pkg::geom_t             g_d;
    cst_pkg::dv_t               c_d;
    cst_pkg::ds_t               d_d;
    logic                       out_valid_reg;
    cst_pkg::out_t              out_reg;

    function automatic logic [63:0] fmt(input logic [cst_pkg::QUOT_W-1:0] q,
                                        input logic neg, input logic ovf);
        logic [63:0] r;
        if (ovf)
            r = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        else
            r = neg ? 64'(-{1'b0, q}) : {1'b0, q};
        return r;
    endfunction

    assign stage_en  = !out_valid_reg || out_ready;
    assign in_ready  = stage_en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_diag_reg  <= cst_pkg::COEF_DIAG_RST;
            coef_off_reg   <= cst_pkg::COEF_OFF_RST;
            coef_shear_reg <= cst_pkg::COEF_SHEAR_RST;
        end
        else if (cfg_valid)
        begin
            case (cst_pkg::cfg_idx_t'(cfg_index))
                cst_pkg::CFG_COEF_DIAG:  coef_diag_reg  <= cfg_data;
                cst_pkg::CFG_COEF_OFF:   coef_off_reg   <= cfg_data;
                cst_pkg::CFG_COEF_SHEAR: coef_shear_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    cst_geom u_geom (
        .clk, .rst_n, .en(stage_en),
        .in_vld(in_valid && stage_en), .in_d(in_data),
        .out_vld(g_vld), .out_d(g_d)
    );

    cst_coef u_coef (
        .clk, .rst_n, .en(stage_en),
        .coef_diag(coef_diag_reg), .coef_off(coef_off_reg), .coef_shear(coef_shear_reg),
        .in_vld(g_vld), .in_d(g_d),
        .out_vld(c_vld), .out_d(c_d)
    );

    cst_div u_div (
        .clk, .rst_n, .en(stage_en),
        .in_vld(c_vld), .in_d(c_d),
        .out_vld(d_vld), .out_d(d_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stage_en)
            out_valid_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en)
        begin
            out_reg.degenerate <= d_d.side.degen;
            if (d_d.side.degen)
            begin
                out_reg.stress_xx     <= '0;
                out_reg.stress_yy     <= '0;
                out_reg.shear_by_area <= '0;
            end
            else
            begin
                out_reg.stress_xx     <= fmt(d_d.q_x, d_d.side.neg_x, d_d.side.ovf_x);
                out_reg.stress_yy     <= fmt(d_d.q_y, d_d.side.neg_y, d_d.side.ovf_y);
                out_reg.shear_by_area <= d_d.side.shear;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
            out_data.stress_xx == 0 && out_data.stress_yy == 0
            && out_data.shear_by_area == 0)
        else $error("degenerate result carries nonzero stress");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_en |=> $stable(d_vld) && $stable(c_vld) && $stable(g_vld))
        else $error("pipeline moved during a stall");

    a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("item accepted while output stalled");

endmodule
